// ===== src/dfq_pkg.sv =====
// Package for the keyed FIFO queue with duplicate key rejection.
// Holds default sizes, operation and status codes, and the controller/datapath
// command and status structs. Depends on nothing.
package dfq_pkg;

  localparam int DEF_QUEUE_DEPTH  = 16;
  localparam int DEF_KEY_BITS     = 32;
  localparam int DEF_PAYLOAD_BITS = 32;
  localparam int OP_BITS          = 2;
  localparam int STATUS_BITS      = 3;

  typedef enum logic [OP_BITS-1:0] {
    OP_INSERT = 2'd0,
    OP_REMOVE = 2'd1,
    OP_PEEK   = 2'd2,
    OP_SEARCH = 2'd3
  } op_t;

  typedef enum logic [STATUS_BITS-1:0] {
    ST_OK       = 3'd0,
    ST_DUP      = 3'd1,
    ST_FULL     = 3'd2,
    ST_EMPTY    = 3'd3,
    ST_NOTFOUND = 3'd4
  } status_t;

  typedef struct packed {
    logic    load;
    logic    step;
    logic    issue_head;
    logic    capture;
    status_t cap_status;
    logic    cap_data;
    logic    cap_write;
    logic    cap_pop;
    logic    emit;
  } dfq_cmd_t;

  typedef struct packed {
    op_t  op;
    logic empty;
    logic full;
    logic match;
    logic scan_done;
    logic out_free;
  } dfq_stat_t;

endpackage

// ===== src/dfq_if.sv =====
// Valid/ready channel interfaces for the request and response items.
// Depends on dfq_pkg for default widths and code widths.
interface dfq_req_if #(
  parameter int KEY_BITS     = dfq_pkg::DEF_KEY_BITS,
  parameter int PAYLOAD_BITS = dfq_pkg::DEF_PAYLOAD_BITS
);
  import dfq_pkg::*;

  logic                    valid;
  logic                    ready;
  logic [OP_BITS-1:0]      op;
  logic [KEY_BITS-1:0]     key;
  logic [PAYLOAD_BITS-1:0] payload;

  modport source (output valid, output op, output key, output payload, input ready);
  modport sink   (input valid, input op, input key, input payload, output ready);
endinterface

interface dfq_rsp_if #(
  parameter int KEY_BITS     = dfq_pkg::DEF_KEY_BITS,
  parameter int PAYLOAD_BITS = dfq_pkg::DEF_PAYLOAD_BITS,
  parameter int COUNT_BITS   = $clog2(dfq_pkg::DEF_QUEUE_DEPTH + 1)
);
  import dfq_pkg::*;

  logic                    valid;
  logic                    ready;
  logic [STATUS_BITS-1:0]  status;
  logic [KEY_BITS-1:0]     out_key;
  logic [PAYLOAD_BITS-1:0] out_payload;
  logic [COUNT_BITS-1:0]   count;
  logic                    is_empty;

  modport source (output valid, output status, output out_key, output out_payload,
                  output count, output is_empty, input ready);
  modport sink   (input valid, input status, input out_key, input out_payload,
                  input count, input is_empty, output ready);
endinterface

// ===== src/dfq_ctrl.sv =====
// Controller state machine of the keyed FIFO queue.
// Sequences decode, key scan, head read, result capture and result hand-off.
// Depends on dfq_pkg for the command and status structs.
module dfq_ctrl (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_ready,
  output dfq_pkg::dfq_cmd_t  cmd,
  input  dfq_pkg::dfq_stat_t stat
);
  import dfq_pkg::*;

  typedef enum logic [2:0] {
    S_IDLE,
    S_DECODE,
    S_HEAD,
    S_SCAN,
    S_RESULT
  } state_t;

  state_t state;
  state_t state_next;

  always_comb begin
    cmd        = '0;
    state_next = state;
    case (state)
      S_IDLE: begin
        if (in_valid && in_ready) begin
          cmd.load   = 1'b1;
          state_next = S_DECODE;
        end
      end
      S_DECODE: begin
        case (stat.op)
          OP_REMOVE, OP_PEEK: begin
            if (stat.empty) begin
              cmd.capture    = 1'b1;
              cmd.cap_status = ST_EMPTY;
              state_next     = S_RESULT;
            end else begin
              cmd.issue_head = 1'b1;
              state_next     = S_HEAD;
            end
          end
          default: begin
            cmd.step   = 1'b1;
            state_next = S_SCAN;
          end
        endcase
      end
      S_HEAD: begin
        cmd.capture    = 1'b1;
        cmd.cap_status = ST_OK;
        cmd.cap_data   = 1'b1;
        cmd.cap_pop    = (stat.op == OP_REMOVE);
        state_next     = S_RESULT;
      end
      S_SCAN: begin
        if (stat.match) begin
          cmd.capture = 1'b1;
          if (stat.op == OP_INSERT) begin
            cmd.cap_status = ST_DUP;
          end else begin
            cmd.cap_status = ST_OK;
            cmd.cap_data   = 1'b1;
          end
          state_next = S_RESULT;
        end else if (stat.scan_done) begin
          cmd.capture = 1'b1;
          if (stat.op == OP_INSERT) begin
            if (stat.full) begin
              cmd.cap_status = ST_FULL;
            end else begin
              cmd.cap_status = ST_OK;
              cmd.cap_write  = 1'b1;
            end
          end else begin
            cmd.cap_status = ST_NOTFOUND;
          end
          state_next = S_RESULT;
        end else begin
          cmd.step = 1'b1;
        end
      end
      S_RESULT: begin
        if (stat.out_free) begin
          cmd.emit   = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_IDLE;
      in_ready <= 1'b1;
    end else begin
      state    <= state_next;
      in_ready <= (state_next == S_IDLE);
    end
  end

endmodule

// ===== src/dfq_datapath.sv =====
// Datapath of the keyed FIFO queue: entry memories, head and count registers,
// the key scan pipeline and the result and output registers.
// Depends on dfq_pkg and on dfq_rsp_if for the response channel.
module dfq_datapath #(
  parameter int QUEUE_DEPTH  = dfq_pkg::DEF_QUEUE_DEPTH,
  parameter int KEY_BITS     = dfq_pkg::DEF_KEY_BITS,
  parameter int PAYLOAD_BITS = dfq_pkg::DEF_PAYLOAD_BITS
) (
  input  logic                         clk,
  input  logic                         rst,
  input  dfq_pkg::dfq_cmd_t            cmd,
  output dfq_pkg::dfq_stat_t           stat,
  input  logic [dfq_pkg::OP_BITS-1:0]  in_op,
  input  logic [KEY_BITS-1:0]          in_key,
  input  logic [PAYLOAD_BITS-1:0]      in_payload,
  dfq_rsp_if.source                    rsp
);
  import dfq_pkg::*;

  localparam int AW = $clog2(QUEUE_DEPTH);
  localparam int CW = $clog2(QUEUE_DEPTH + 1);
  localparam int SW = AW + 1;

  logic [KEY_BITS-1:0]     key_mem [QUEUE_DEPTH];
  logic [PAYLOAD_BITS-1:0] pay_mem [QUEUE_DEPTH];

  op_t                     op_r;
  logic [KEY_BITS-1:0]     key_r;
  logic [PAYLOAD_BITS-1:0] pay_r;
  logic [AW-1:0]           head;
  logic [CW-1:0]           count;
  logic [CW-1:0]           count_next;
  logic [CW-1:0]           scan_idx;
  logic                    cmp_valid;
  logic [KEY_BITS-1:0]     rd_key;
  logic [PAYLOAD_BITS-1:0] rd_pay;

  status_t                 res_status;
  logic [KEY_BITS-1:0]     res_key;
  logic [PAYLOAD_BITS-1:0] res_pay;
  logic [CW-1:0]           res_count;

  logic                    out_valid;
  status_t                 out_status;
  logic [KEY_BITS-1:0]     out_key;
  logic [PAYLOAD_BITS-1:0] out_pay;
  logic [CW-1:0]           out_count;
  logic                    out_empty;

  logic [AW-1:0]           scan_slot;
  logic [AW-1:0]           tail_slot;
  logic [AW-1:0]           head_next;
  logic [AW-1:0]           rd_addr;
  logic                    issue_ok;
  logic                    out_free;

  function automatic logic [AW-1:0] wrap_slot(logic [AW-1:0] base, logic [CW-1:0] offset);
    logic [SW-1:0] sum;
    sum = SW'(base) + SW'(offset);
    if (sum >= SW'(QUEUE_DEPTH)) begin
      sum = sum - SW'(QUEUE_DEPTH);
    end
    return sum[AW-1:0];
  endfunction

  assign scan_slot = wrap_slot(head, scan_idx);
  assign tail_slot = wrap_slot(head, count);
  assign head_next = wrap_slot(head, CW'(1));
  assign rd_addr   = cmd.issue_head ? head : scan_slot;
  assign issue_ok  = (scan_idx < count);
  assign out_free  = !out_valid || rsp.ready;

  always_comb begin
    count_next = count;
    if (cmd.cap_write) begin
      count_next = count + CW'(1);
    end else if (cmd.cap_pop) begin
      count_next = count - CW'(1);
    end
  end

  assign stat.op        = op_r;
  assign stat.empty     = (count == '0);
  assign stat.full      = (count == CW'(QUEUE_DEPTH));
  assign stat.match     = cmp_valid && (rd_key == key_r);
  assign stat.scan_done = !issue_ok && !cmp_valid;
  assign stat.out_free  = out_free;

  always_ff @(posedge clk) begin
    if (cmd.capture && cmd.cap_write) begin
      key_mem[tail_slot] <= key_r;
      pay_mem[tail_slot] <= pay_r;
    end
    rd_key <= key_mem[rd_addr];
    rd_pay <= pay_mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      op_r  <= op_t'(in_op);
      key_r <= in_key;
      pay_r <= in_payload;
    end
    if (cmd.capture) begin
      res_status <= cmd.cap_status;
      res_key    <= cmd.cap_data ? rd_key : '0;
      res_pay    <= cmd.cap_data ? rd_pay : '0;
      res_count  <= count_next;
    end
    if (cmd.emit) begin
      out_status <= res_status;
      out_key    <= res_key;
      out_pay    <= res_pay;
      out_count  <= res_count;
      out_empty  <= (res_count == '0);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      head      <= '0;
      count     <= '0;
      scan_idx  <= '0;
      cmp_valid <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (cmd.load) begin
        scan_idx  <= '0;
        cmp_valid <= 1'b0;
      end else begin
        if (cmd.step && issue_ok) begin
          scan_idx <= scan_idx + CW'(1);
        end
        cmp_valid <= cmd.step && issue_ok;
      end
      if (cmd.capture) begin
        count <= count_next;
        if (cmd.cap_pop) begin
          head <= head_next;
        end
      end
      if (cmd.emit) begin
        out_valid <= 1'b1;
      end else if (rsp.ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  assign rsp.valid       = out_valid;
  assign rsp.status      = out_status;
  assign rsp.out_key     = out_key;
  assign rsp.out_payload = out_pay;
  assign rsp.count       = out_count;
  assign rsp.is_empty    = out_empty;

`ifndef SYNTHESIS
  a_write_room : assert property (@(posedge clk) disable iff (rst)
    cmd.capture && cmd.cap_write |-> count < CW'(QUEUE_DEPTH))
    else $error("entry written into a full queue");

  a_pop_live : assert property (@(posedge clk) disable iff (rst)
    cmd.capture && cmd.cap_pop |-> count != '0)
    else $error("head removed from an empty queue");

  a_count_up : assert property (@(posedge clk) disable iff (rst)
    cmd.capture && cmd.cap_write |=> count == $past(count) + CW'(1))
    else $error("count did not rise after an insert");

  a_emit_free : assert property (@(posedge clk) disable iff (rst)
    cmd.emit |-> !out_valid || rsp.ready)
    else $error("result overwrote an item not yet taken");

  a_cmp_issued : assert property (@(posedge clk) disable iff (rst)
    cmp_valid |-> scan_idx != '0)
    else $error("key compare without an issued read");
`endif

endmodule

// ===== src/dedup_fifo_queue.sv =====
// Keyed FIFO queue with duplicate key rejection, top level.
// Joins the controller and the datapath to the request and response channels.
// Depends on dfq_pkg, dfq_if, dfq_ctrl and dfq_datapath.
//
// The queue holds up to QUEUE_DEPTH entries of a key and a payload in a circular
// buffer kept in one memory per field, with one write port and one registered read port.
// It works on one item at a time. Insert and search read the live keys one per cycle
// from the head and compare each against the item's key; the scan stops early on a
// match. Remove and peek read only the head slot, and skip the read when the queue is
// empty. A finished result moves into an output register, and the next item can be
// accepted while that result still waits to be taken; a result that is not taken
// holds the following one back. There is no clearing pass after reset; the queue is
// ready as soon as reset is released.
module dedup_fifo_queue #(
  parameter int QUEUE_DEPTH  = dfq_pkg::DEF_QUEUE_DEPTH,
  parameter int KEY_BITS     = dfq_pkg::DEF_KEY_BITS,
  parameter int PAYLOAD_BITS = dfq_pkg::DEF_PAYLOAD_BITS
) (
  input logic       clk,
  input logic       rst,
  dfq_req_if.sink   req,
  dfq_rsp_if.source rsp
);
  import dfq_pkg::*;

  dfq_cmd_t  cmd;
  dfq_stat_t stat;

  dfq_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (req.valid),
    .in_ready (req.ready),
    .cmd      (cmd),
    .stat     (stat)
  );

  dfq_datapath #(
    .QUEUE_DEPTH  (QUEUE_DEPTH),
    .KEY_BITS     (KEY_BITS),
    .PAYLOAD_BITS (PAYLOAD_BITS)
  ) u_datapath (
    .clk        (clk),
    .rst        (rst),
    .cmd        (cmd),
    .stat       (stat),
    .in_op      (req.op),
    .in_key     (req.key),
    .in_payload (req.payload),
    .rsp        (rsp)
  );

endmodule

// ===== test/tb_top.sv =====
`timescale 1ns / 1ps
// Self-checking testbench for dedup_fifo_queue: directed corner items, then random items.
// A mirror of the queue predicts each response. Depends on dfq_pkg, dfq_if and the RTL.

import dfq_pkg::*;

typedef struct packed {
  status_t     status;
  logic [31:0] key;
  logic [31:0] payload;
  logic [4:0]  count;
  logic        is_empty;
} queue_result_t;

class queue_mirror;
  logic [31:0]   keys [DEF_QUEUE_DEPTH];
  logic [31:0]   payloads [DEF_QUEUE_DEPTH];
  logic [3:0]    head;
  logic [4:0]    held_count;
  queue_result_t awaited[$];
  int            errors;

  function new();
    head = '0;
    held_count = '0;
    errors = 0;
  endfunction

  function int held();
    return held_count;
  endfunction

  function int pending();
    return awaited.size();
  endfunction

  function logic [31:0] key_at(int offset);
    logic [3:0] slot;
    slot = head + 4'(offset);
    return keys[slot];
  endfunction

  function int locate(logic [31:0] key);
    logic [3:0] slot;
    for (int i = 0; i < held_count; i++) begin
      slot = head + 4'(i);
      if (keys[slot] == key) return i;
    end
    return -1;
  endfunction

  function void note_request(op_t op, logic [31:0] key, logic [31:0] payload);
    queue_result_t res;
    int            hit;
    logic [3:0]    slot;
    res.status = ST_OK;
    res.key = '0;
    res.payload = '0;
    case (op)
      OP_INSERT: begin
        if (locate(key) >= 0) begin
          res.status = ST_DUP;
        end else if (held_count == DEF_QUEUE_DEPTH) begin
          res.status = ST_FULL;
        end else begin
          slot = head + held_count[3:0];
          keys[slot] = key;
          payloads[slot] = payload;
          held_count = held_count + 1'b1;
        end
      end
      OP_REMOVE, OP_PEEK: begin
        if (held_count == 0) begin
          res.status = ST_EMPTY;
        end else begin
          res.key = keys[head];
          res.payload = payloads[head];
          if (op == OP_REMOVE) begin
            head = head + 1'b1;
            held_count = held_count - 1'b1;
          end
        end
      end
      default: begin
        hit = locate(key);
        if (hit < 0) begin
          res.status = ST_NOTFOUND;
        end else begin
          slot = head + 4'(hit);
          res.key = keys[slot];
          res.payload = payloads[slot];
        end
      end
    endcase
    res.count = held_count;
    res.is_empty = (held_count == 0);
    awaited.push_back(res);
  endfunction

  function void check_response(queue_result_t got);
    queue_result_t want;
    if (awaited.size() == 0) begin
      errors++;
      if (errors <= 10)
        $display("%0t: response with none expected: status %0d key %h payload %h count %0d",
                 $time, got.status, got.key, got.payload, got.count);
      return;
    end
    want = awaited.pop_front();
    if (got.status !== want.status || got.key !== want.key || got.payload !== want.payload ||
        got.count !== want.count || got.is_empty !== want.is_empty) begin
      errors++;
      if (errors <= 10) begin
        $display("%0t: response mismatch", $time);
        $display("  expected status %0d key %h payload %h count %0d empty %0d",
                 want.status, want.key, want.payload, want.count, want.is_empty);
        $display("  actual   status %0d key %h payload %h count %0d empty %0d",
                 got.status, got.key, got.payload, got.count, got.is_empty);
      end
    end
  endfunction
endclass

module tb_top;
  logic        clk;
  logic        rst;
  bit          calm;
  bit          filling;
  queue_mirror mirror;

  dfq_req_if req ();
  dfq_rsp_if rsp ();

  dedup_fifo_queue uut (
    .clk(clk),
    .rst(rst),
    .req(req),
    .rsp(rsp)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  initial begin
    #5_000_000;
    $display("[FAIL] regression broken");
    $finish;
  end

  function automatic int pick_gap();
    int r;
    if (calm) return 0;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  function automatic op_t pick_op();
    int r;
    r = $urandom_range(0, 99);
    if (filling) begin
      if (r < 55) return OP_INSERT;
      if (r < 70) return OP_REMOVE;
      if (r < 82) return OP_PEEK;
      return OP_SEARCH;
    end
    if (r < 15) return OP_INSERT;
    if (r < 65) return OP_REMOVE;
    if (r < 78) return OP_PEEK;
    return OP_SEARCH;
  endfunction

  function automatic logic [31:0] pick_key();
    int r;
    r = $urandom_range(0, 99);
    if (r < 45 && mirror.held() > 0) return mirror.key_at($urandom_range(0, mirror.held() - 1));
    if (r < 75) return 32'($urandom_range(0, 23));
    if (r < 80) return 32'hFFFF_FFFF;
    return $urandom;
  endfunction

  function automatic logic [31:0] pick_payload();
    int r;
    r = $urandom_range(0, 99);
    if (r < 10) return 32'h0;
    if (r < 20) return 32'hFFFF_FFFF;
    return $urandom;
  endfunction

  task automatic send_request(op_t op, logic [31:0] key, logic [31:0] payload);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      req.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    req.valid <= 1'b1;
    req.op <= op;
    req.key <= key;
    req.payload <= payload;
    @(posedge clk);
    while (!req.ready) @(posedge clk);
    mirror.note_request(op, key, payload);
  endtask

  initial begin
    int            stall;
    queue_result_t got;
    stall = 0;
    rsp.ready <= 1'b0;
    @(posedge clk);
    while (rst) @(posedge clk);
    forever begin
      if (rsp.valid && rsp.ready) begin
        got.status = status_t'(rsp.status);
        got.key = rsp.out_key;
        got.payload = rsp.out_payload;
        got.count = rsp.count;
        got.is_empty = rsp.is_empty;
        mirror.check_response(got);
      end
      if (stall == 0 && $urandom_range(0, 3) == 0) stall = pick_gap();
      rsp.ready <= (stall == 0);
      if (stall > 0) stall--;
      @(posedge clk);
    end
  end

  initial begin
    int phase_left;
    mirror = new();
    calm = 1'b0;
    filling = 1'b1;
    phase_left = 0;
    rst <= 1'b1;
    req.valid <= 1'b0;
    req.op <= OP_INSERT;
    req.key <= '0;
    req.payload <= '0;
    repeat (7) @(posedge clk);
    rst <= 1'b0;

    // Empty queue: remove, peek and search all miss.
    send_request(OP_REMOVE, 32'h0, 32'h0);
    send_request(OP_PEEK, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    send_request(OP_SEARCH, 32'hFFFF_FFFF, 32'h0);
    send_request(OP_INSERT, 32'h0, 32'hFFFF_FFFF);
    send_request(OP_INSERT, 32'hFFFF_FFFF, 32'h0);
    send_request(OP_INSERT, 32'h0, 32'h1234_5678);
    send_request(OP_SEARCH, 32'hFFFF_FFFF, 32'h0);
    send_request(OP_SEARCH, 32'h5A5A_5A5A, 32'h0);
    send_request(OP_PEEK, 32'h0, 32'h0);
    send_request(OP_REMOVE, 32'h0, 32'h0);
    for (int i = 0; i < 15; i++)
      send_request(OP_INSERT, 32'h8000_0000 | 32'(i), ~32'(i));
    // Full queue: a new key is refused, a stored key is still reported as a duplicate.
    send_request(OP_INSERT, 32'h00C0_FFEE, 32'h0);
    send_request(OP_INSERT, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    send_request(OP_SEARCH, 32'h8000_000E, 32'h0);

    for (int n = 0; n < 1320; n++) begin
      if (n % 100 == 0) calm = ($urandom_range(0, 3) == 0);
      if (phase_left == 0) begin
        filling = !filling;
        phase_left = $urandom_range(20, 60);
      end
      phase_left--;
      send_request(pick_op(), pick_key(), pick_payload());
    end
    req.valid <= 1'b0;

    while (mirror.pending() != 0) @(posedge clk);
    repeat (40) @(posedge clk);
    if (mirror.errors == 0 && mirror.pending() == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end
endmodule

// ===== files.f =====
src/dfq_pkg.sv
src/dfq_if.sv
src/dfq_ctrl.sv
src/dfq_datapath.sv
src/dedup_fifo_queue.sv
test/tb_top.sv
